/* rtl/core/tapc_pkg.sv */
// Shared types and constants for the three-axis PID position controller.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package tapc_pkg;

    // Channel count is set by the fixed a/b/c word fields.
    localparam int CHANNELS      = 3;
    localparam int FRAC_BITS_DEF = 16;

    // Field and register widths.
    localparam int POS_W   = 16;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int GAIN_W  = 20;
    localparam int LIMIT_W = 7;
    localparam int DRIVE_W = 8;
    localparam int IDX_W   = 3;

    // Products of a 21-bit signed gain and an 18-bit signed operand.
    localparam int PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int RAW_W  = PROD_W + 1;
    localparam int SUM_W  = RAW_W + 1;

    localparam int DRIVE_MAX = 100;

    // Register indexes on the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN_A = 3'd0,
        REG_PROP_GAIN_B = 3'd1,
        REG_PROP_GAIN_C = 3'd2,
        REG_INTEG_GAIN  = 3'd3,
        REG_DERIV_GAIN  = 3'd4,
        REG_INTEG_LIMIT = 3'd5
    } tapc_reg_t;

    // Reset values of the registers.
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN_A = 20'd32768;
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN_B = 20'd32768;
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN_C = 20'd65536;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = 20'd66;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = 20'd65536;
    localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 7'd10;

    // Current register contents as seen by the lanes.
    typedef struct packed {
        logic [CHANNELS-1:0][GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0]               integ_gain;
        logic [GAIN_W-1:0]               deriv_gain;
        logic [LIMIT_W-1:0]              integ_limit;
    } tapc_cfg_t;

    // Per-stage advance strobes from the pipeline control.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } tapc_adv_t;

endpackage

/* rtl/core/tapc_cfg.sv */
// Configuration register file for the PID controller.
// Depends on tapc_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps

module tapc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tapc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [tapc_pkg::GAIN_W-1:0] cfg_data,
    output tapc_pkg::tapc_cfg_t         cfg
);
    import tapc_pkg::*;

    tapc_cfg_t cfg_reg;
    tapc_cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tapc_reg_t'(cfg_index))
                REG_PROP_GAIN_A: cfg_next.prop_gain[0] = cfg_data;
                REG_PROP_GAIN_B: cfg_next.prop_gain[1] = cfg_data;
                REG_PROP_GAIN_C: cfg_next.prop_gain[2] = cfg_data;
                REG_INTEG_GAIN:  cfg_next.integ_gain   = cfg_data;
                REG_DERIV_GAIN:  cfg_next.deriv_gain   = cfg_data;
                REG_INTEG_LIMIT: cfg_next.integ_limit  = cfg_data[LIMIT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain[0] <= RST_PROP_GAIN_A;
            cfg_reg.prop_gain[1] <= RST_PROP_GAIN_B;
            cfg_reg.prop_gain[2] <= RST_PROP_GAIN_C;
            cfg_reg.integ_gain   <= RST_INTEG_GAIN;
            cfg_reg.deriv_gain   <= RST_DERIV_GAIN;
            cfg_reg.integ_limit  <= RST_INTEG_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/tapc_ctrl.sv */
// Valid tracking and advance strobes for the five-stage pipeline.
// Depends on tapc_pkg for the advance strobe struct.
`timescale 1ns / 1ps

module tapc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output tapc_pkg::tapc_adv_t adv
);
    import tapc_pkg::*;

    localparam int NSTAGE = 5;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] ready;
    logic [NSTAGE-1:0] take;
    logic [NSTAGE-1:0] load;

    // A stage can load when it is empty or its word moves on this cycle.
    always_comb
    begin
        take[NSTAGE-1]  = valid_reg[NSTAGE-1] & ~out_stall;
        ready[NSTAGE-1] = ~valid_reg[NSTAGE-1] | ~out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            take[k]  = valid_reg[k] & ready[k+1];
            ready[k] = ~valid_reg[k] | ready[k+1];
        end
        load[0] = in_valid & ready[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            load[k] = take[k-1];
        end
        valid_next = load | (valid_reg & ~take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = ~ready[0];
    assign out_valid = valid_reg[NSTAGE-1];

    assign adv.s1 = load[0];
    assign adv.s2 = load[1];
    assign adv.s3 = load[2];
    assign adv.s4 = load[3];
    assign adv.s5 = load[4];

endmodule

/* rtl/core/tapc_lane.sv */
// One PID channel: error, gain products, clamped integral and the exact sum.
// Depends on tapc_pkg for widths and the advance strobe struct.
`timescale 1ns / 1ps

module tapc_lane #(
    parameter int FRAC_BITS = tapc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tapc_pkg::tapc_adv_t                 adv,
    input  logic signed [tapc_pkg::POS_W-1:0]   target,
    input  logic signed [tapc_pkg::POS_W-1:0]   position,
    input  logic        [tapc_pkg::GAIN_W-1:0]  prop_gain,
    input  logic        [tapc_pkg::GAIN_W-1:0]  integ_gain,
    input  logic        [tapc_pkg::GAIN_W-1:0]  deriv_gain,
    input  logic        [tapc_pkg::LIMIT_W-1:0] integ_limit,
    output logic signed [tapc_pkg::SUM_W-1:0]   sum
);
    import tapc_pkg::*;

    localparam int ACC_W = FRAC_BITS + LIMIT_W + 1;

    // Channel state.
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Pipeline words.
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] pp_reg;
    logic signed [PROD_W-1:0] ip_reg;
    logic signed [PROD_W-1:0] dp_reg;
    logic signed [RAW_W-1:0]  pd_reg;
    logic signed [ACC_W-1:0]  accv_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic signed [ERR_W-1:0]  err_next;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [PROD_W-1:0] pp_next;
    logic signed [PROD_W-1:0] ip_next;
    logic signed [PROD_W-1:0] dp_next;
    logic signed [RAW_W-1:0]  acc_raw;
    logic signed [RAW_W-1:0]  bound;
    logic signed [RAW_W-1:0]  acc_clamp;
    logic signed [RAW_W-1:0]  pd_next;
    logic signed [SUM_W-1:0]  sum_next;

    // Stage one: error and its change since the previous tick.
    assign err_next  = ERR_W'(target) - ERR_W'(position);
    assign diff_next = DIFF_W'(err_next) - DIFF_W'(prev_err_reg);

    // Stage two: the three gain products.
    assign pp_next = PROD_W'($signed({1'b0, prop_gain}) * err_reg);
    assign ip_next = PROD_W'($signed({1'b0, integ_gain}) * err_reg);
    assign dp_next = PROD_W'($signed({1'b0, deriv_gain}) * diff_reg);

    // Stage three: integrate and clamp to the symmetric bound; add the proportional and derivative products.
    assign acc_raw = RAW_W'(acc_reg) + RAW_W'(ip_reg);
    assign bound   = RAW_W'($signed({1'b0, integ_limit, {FRAC_BITS{1'b0}}}));
    assign pd_next = RAW_W'(pp_reg) + RAW_W'(dp_reg);

    always_comb
    begin
        if (acc_raw > bound)
        begin
            acc_clamp = bound;
        end
        else if (acc_raw < -bound)
        begin
            acc_clamp = -bound;
        end
        else
        begin
            acc_clamp = acc_raw;
        end
    end

    // Stage four: exact sum of all three terms.
    assign sum_next = SUM_W'(pd_reg) + SUM_W'(accv_reg);

    // State registers, cleared on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            if (adv.s1)
            begin
                prev_err_reg <= err_next;
            end
            if (adv.s3)
            begin
                acc_reg <= ACC_W'(acc_clamp);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
        end
        if (adv.s2)
        begin
            pp_reg <= pp_next;
            ip_reg <= ip_next;
            dp_reg <= dp_next;
        end
        if (adv.s3)
        begin
            pd_reg   <= pd_next;
            accv_reg <= ACC_W'(acc_clamp);
        end
        if (adv.s4)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

/* rtl/core/tapc_merge.sv */
// Output stage: truncates each lane's sum toward zero, saturates it and
// registers all drive values together. Depends on tapc_pkg.
`timescale 1ns / 1ps

module tapc_merge #(
    parameter int FRAC_BITS = tapc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  tapc_pkg::tapc_adv_t                 adv,
    input  logic signed [tapc_pkg::SUM_W-1:0]   sums  [tapc_pkg::CHANNELS],
    output logic signed [tapc_pkg::DRIVE_W-1:0] drives [tapc_pkg::CHANNELS]
);
    import tapc_pkg::*;

    localparam int T_W = SUM_W - FRAC_BITS;
    localparam logic [SUM_W-1:0] FRAC_MASK = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [T_W-1:0] POS_LIM = T_W'(DRIVE_MAX);
    localparam logic signed [T_W-1:0] NEG_LIM = -POS_LIM;

    logic signed [SUM_W-1:0]   biased     [CHANNELS];
    logic signed [SUM_W-1:0]   shifted    [CHANNELS];
    logic signed [T_W-1:0]     whole      [CHANNELS];
    logic signed [DRIVE_W-1:0] drive_next [CHANNELS];
    logic signed [DRIVE_W-1:0] drive_reg  [CHANNELS];

    // A negative sum is biased by the fraction mask so the shift truncates
    // toward zero; the whole part is then saturated.
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            biased[i]  = sums[i] + (sums[i][SUM_W-1] ? $signed(FRAC_MASK) : $signed(SUM_W'(0)));
            shifted[i] = biased[i] >>> FRAC_BITS;
            whole[i]   = $signed(shifted[i][T_W-1:0]);
            if (whole[i] > POS_LIM)
            begin
                drive_next[i] = DRIVE_W'(POS_LIM);
            end
            else if (whole[i] < NEG_LIM)
            begin
                drive_next[i] = DRIVE_W'(NEG_LIM);
            end
            else
            begin
                drive_next[i] = DRIVE_W'(whole[i]);
            end
        end
    end

    // Output register; holds while the word is stalled.
    always_ff @(posedge clk)
    begin
        if (adv.s5)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drives = drive_reg;

endmodule

/* rtl/core/three_axis_pid_position_control.sv */
// Top level of the three-axis PID position controller with integral clamp.
// Depends on tapc_pkg, tapc_cfg, tapc_ctrl, tapc_lane and tapc_merge.
//
//   Channel   Handshake               Word
//   input     in_valid / in_stall     target_a..c, position_a..c (16-bit signed)
//   output    out_valid / out_stall   drive_a..c (8-bit signed, -100..100)
//   config    cfg_we                  cfg_index (3 bits), cfg_data (20 bits)
//
// One word is accepted per cycle while in_stall is low; its drive values pass
// through the five register stages error, products, integral, sum, output.
// Each channel's integral and previous error are updated in place, so
// consecutive words follow each other without gaps.
// Reset clears the channel state and loads the default gains and limit.
// A stalled output holds its word; the pipeline keeps filling empty stages
// and stalls the input only when every stage is occupied.
`timescale 1ns / 1ps

module three_axis_pid_position_control #(
    parameter int FRAC_BITS = tapc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [tapc_pkg::POS_W-1:0]   target_a,
    input  logic signed [tapc_pkg::POS_W-1:0]   target_b,
    input  logic signed [tapc_pkg::POS_W-1:0]   target_c,
    input  logic signed [tapc_pkg::POS_W-1:0]   position_a,
    input  logic signed [tapc_pkg::POS_W-1:0]   position_b,
    input  logic signed [tapc_pkg::POS_W-1:0]   position_c,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tapc_pkg::DRIVE_W-1:0] drive_a,
    output logic signed [tapc_pkg::DRIVE_W-1:0] drive_b,
    output logic signed [tapc_pkg::DRIVE_W-1:0] drive_c,
    input  logic                                cfg_we,
    input  logic [tapc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [tapc_pkg::GAIN_W-1:0]         cfg_data
);
    import tapc_pkg::*;

    tapc_cfg_t cfg;
    tapc_adv_t adv;

    logic signed [POS_W-1:0]   targets   [CHANNELS];
    logic signed [POS_W-1:0]   positions [CHANNELS];
    logic signed [SUM_W-1:0]   sums      [CHANNELS];
    logic signed [DRIVE_W-1:0] drives    [CHANNELS];

    assign targets[0]   = target_a;
    assign targets[1]   = target_b;
    assign targets[2]   = target_c;
    assign positions[0] = position_a;
    assign positions[1] = position_b;
    assign positions[2] = position_c;

    // Register file.
    tapc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline control.
    tapc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .adv       (adv)
    );

    // One lane per channel.
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        tapc_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .target      (targets[i]),
            .position    (positions[i]),
            .prop_gain   (cfg.prop_gain[i]),
            .integ_gain  (cfg.integ_gain),
            .deriv_gain  (cfg.deriv_gain),
            .integ_limit (cfg.integ_limit),
            .sum         (sums[i])
        );
    end

    // Truncation, saturation and the shared output register.
    tapc_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk    (clk),
        .adv    (adv),
        .sums   (sums),
        .drives (drives)
    );

    assign drive_a = drives[0];
    assign drive_b = drives[1];
    assign drive_c = drives[2];

endmodule
